// ----- hdl/bmsirq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsirq_pkg
// Shared types and constants for the bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmsirq_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BANK_W = 8;
    localparam int NUM_BANKS = 8;
    localparam int BIDX_W = 3;

    // Item kinds on tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_PRG   = 2'd2,
        MODE_CHR   = 2'd3
    } mode_t;

    // Register selected by address bits {14:13, 0} of a write at 0x8000 and up
    typedef enum logic [2:0] {
        WR_BANK_SEL    = 3'b000,
        WR_BANK_DATA   = 3'b001,
        WR_MIRROR      = 3'b010,
        WR_PROTECT     = 3'b011,
        WR_IRQ_LATCH   = 3'b100,
        WR_IRQ_RELOAD  = 3'b101,
        WR_IRQ_DISABLE = 3'b110,
        WR_IRQ_ENABLE  = 3'b111
    } wr_reg_t;

    // Configuration register index (word address bit 2)
    localparam logic CFG_REV_B_IRQ = 1'b0;

    // Bank select bits
    localparam int BS_PRG_SWAP = 6;
    localparam int BS_CHR_SWAP = 7;

    // Protect register value meaning enabled and writable
    localparam logic [1:0] PROT_RW = 2'b10;

    // Fixed PRG banks 0xFE/0xFF masked to 7 bits, less the slot bit
    localparam logic [BANK_W-2:0] PRG_FIXED_HI = 7'h3F;

    typedef logic [BANK_W-1:0] bank_t;

    localparam bank_t BANK_RESET [NUM_BANKS] = '{
        8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
    };

    typedef struct packed {
        mode_t              mode;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  data;
    } item_t;

    typedef struct packed {
        logic       ram_writable;
        logic       ram_enabled;
        logic       mirror_horizontal;
        logic       irq_line;
        bank_t      bank;
    } result_t;

endpackage

// ----- hdl/bmsirq_apb.sv -----
// ----------------------------------------------------------------------------
// bmsirq_apb
// APB configuration register: IRQ revision select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsirq_apb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        rev_b_irq
);
    import bmsirq_pkg::*;

    logic rev_b_reg;
    logic rev_b_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        rev_b_next = rev_b_reg;
        if (wr_en && paddr[2] == CFG_REV_B_IRQ) begin
            rev_b_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_b_reg <= 1'b1;
        end else begin
            rev_b_reg <= rev_b_next;
        end
    end

    assign prdata    = (paddr[2] == CFG_REV_B_IRQ) ? {31'd0, rev_b_reg} : 32'd0;
    assign rev_b_irq = rev_b_reg;

endmodule

// ----- hdl/bmsirq_core.sv -----
// ----------------------------------------------------------------------------
// bmsirq_core
// Mapper state, write decode, scanline counter and bank lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsirq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  bmsirq_pkg::item_t   item,
    input  logic                rev_b_irq,
    output bmsirq_pkg::result_t result
);
    import bmsirq_pkg::*;

    bank_t              bank_regs_reg [NUM_BANKS];
    logic [7:0]         bank_select_reg, bank_select_next;
    logic               mirror_reg, mirror_next;
    logic [1:0]         protect_reg, protect_next;
    logic [7:0]         latch_reg, latch_next;
    logic [7:0]         counter_reg, counter_next;
    logic               reload_reg, reload_next;
    logic               irq_en_reg, irq_en_next;
    logic               irq_reg, irq_next;

    logic               bank_wr;
    wr_reg_t            wr_sel;
    logic [1:0]         prg_slot;
    logic [2:0]         chr_slot;
    logic [BIDX_W-1:0]  rd_idx;
    bank_t              rd_bank;
    bank_t              bank_out;

    assign wr_sel = wr_reg_t'({item.address[14:13], item.address[0]});

    always_comb begin
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        protect_next     = protect_reg;
        latch_next       = latch_reg;
        counter_next     = counter_reg;
        reload_next      = reload_reg;
        irq_en_next      = irq_en_reg;
        irq_next         = irq_reg;
        bank_wr          = 1'b0;

        case (item.mode)
            MODE_WRITE: begin
                if (item.address[15]) begin
                    case (wr_sel)
                        WR_BANK_SEL:    bank_select_next = item.data;
                        WR_BANK_DATA:   bank_wr = 1'b1;
                        WR_MIRROR:      mirror_next = item.data[0];
                        WR_PROTECT:     protect_next = item.data[7:6];
                        WR_IRQ_LATCH:   latch_next = item.data;
                        WR_IRQ_RELOAD: begin
                            counter_next = 8'd0;
                            reload_next  = 1'b1;
                        end
                        WR_IRQ_DISABLE: begin
                            irq_en_next = 1'b0;
                            irq_next    = 1'b0;
                        end
                        WR_IRQ_ENABLE:  irq_en_next = 1'b1;
                        default:        ;
                    endcase
                end
            end
            MODE_TICK: begin
                if (counter_reg == 8'd0 || reload_reg) begin
                    counter_next = latch_reg;
                    reload_next  = 1'b0;
                end else begin
                    counter_next = counter_reg - 8'd1;
                end
                // Revision A only fires on a decrement reaching zero
                if ((counter_reg != 8'd0 || rev_b_irq) && counter_next == 8'd0
                        && irq_en_reg) begin
                    irq_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Bank lookup: one register-file read, index chosen by lookup kind
    always_comb begin
        prg_slot = item.address[14:13];
        if (!prg_slot[0] && bank_select_reg[BS_PRG_SWAP]) begin
            prg_slot[1] = ~prg_slot[1];
        end
        chr_slot = item.address[12:10];
        if (bank_select_reg[BS_CHR_SWAP]) begin
            chr_slot[2] = ~chr_slot[2];
        end

        if (item.mode == MODE_PRG) begin
            rd_idx = {2'b11, prg_slot[0]};
        end else if (chr_slot[2]) begin
            rd_idx = chr_slot - 3'd2;
        end else begin
            rd_idx = {1'b0, chr_slot[2:1]};
        end
        rd_bank = bank_regs_reg[rd_idx];

        case (item.mode)
            MODE_PRG: begin
                if (prg_slot[1]) begin
                    bank_out = {1'b0, PRG_FIXED_HI[BANK_W-3:0], prg_slot[0]};
                end else begin
                    bank_out = {1'b0, rd_bank[BANK_W-2:0]};
                end
            end
            MODE_CHR: begin
                if (chr_slot[2]) begin
                    bank_out = rd_bank;
                end else begin
                    bank_out = {rd_bank[BANK_W-1:1], chr_slot[0]};
                end
            end
            default: bank_out = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANKS; i++) begin
                bank_regs_reg[i] <= BANK_RESET[i];
            end
            bank_select_reg <= '0;
            mirror_reg      <= 1'b0;
            protect_reg     <= '0;
            latch_reg       <= '0;
            counter_reg     <= '0;
            reload_reg      <= 1'b0;
            irq_en_reg      <= 1'b0;
            irq_reg         <= 1'b0;
        end else if (fire) begin
            if (bank_wr) begin
                bank_regs_reg[bank_select_reg[BIDX_W-1:0]] <= item.data;
            end
            bank_select_reg <= bank_select_next;
            mirror_reg      <= mirror_next;
            protect_reg     <= protect_next;
            latch_reg       <= latch_next;
            counter_reg     <= counter_next;
            reload_reg      <= reload_next;
            irq_en_reg      <= irq_en_next;
            irq_reg         <= irq_next;
        end
    end

    // Flags report the state after this word
    assign result.bank              = bank_out;
    assign result.irq_line          = irq_next;
    assign result.mirror_horizontal = mirror_next;
    assign result.ram_enabled       = protect_next[1];
    assign result.ram_writable      = (protect_next == PROT_RW);

endmodule

// ----- hdl/bank_mapper_with_scanline_irq.sv -----
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper with scanline-counted interrupt, streaming top level.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per input word, in order.
// Each word passes the input register, then decode, state update and
// bank lookup in one pass into the result register. State written by a word
// is seen by the very next word, so throughput is one word per cycle while
// m_tready is held high. Input word kinds on s_tuser: 0 CPU register write,
// 1 scanline tick, 2 PRG lookup, 3 CHR lookup. The result flags show the
// mapper state after the word has been applied; bank is 0 for writes and
// ticks. The only APB register, at address 0, bit 0, selects revision B IRQ
// behaviour (reset 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] address, [23:16] data
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [7:0] bank, [8] irq_line,
                                    // [9] mirror_horizontal, [10] ram_enabled,
                                    // [11] ram_writable, [15:12] zero
);
    import bmsirq_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    core_result;
    logic       rev_b_irq;
    logic       advance;
    logic       fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    bmsirq_apb u_apb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .rev_b_irq (rev_b_irq)
    );

    bmsirq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .rev_b_irq (rev_b_irq),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.mode    <= mode_t'(s_tuser);
            in_item_reg.address <= s_tdata[15:0];
            in_item_reg.data    <= s_tdata[23:16];
        end
        if (fire) begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule
